>>> rtl/core/nsp_pkg.sv
package nsp_pkg;

   // defaults for the top-level parameters
   localparam int DEF_MAX_LINE_CHARS  = 255;
   localparam int DEF_FRACTION_DIGITS = 5;

   // field widths
   localparam int INT_W  = 20;
   localparam int DEG_W  = 14;
   localparam int MIN_W  = 7;
   localparam int HDOP_W = 14;

   // number limits
   localparam logic [INT_W-1:0]  INT_CAP   = 20'd999999;
   localparam logic [DEG_W-1:0]  DEG_MAX   = 14'd9999;
   localparam logic [HDOP_W-1:0] HDOP_CAP  = 14'd9999;
   localparam logic [HDOP_W-1:0] HDOP_ZERO = 14'd100;
   localparam logic [31:0]       DEG_CAP   = 32'd1800000000;
   localparam int                E7        = 10000000;

   // characters
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_G      = 8'h47;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_S      = 8'h53;
   localparam logic [7:0] CH_W      = 8'h57;
   localparam logic [7:0] CH_LS     = 8'h73;
   localparam logic [7:0] CH_LW     = 8'h77;

   // sentence kinds
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_GGA  = 2'd1,
      KIND_RMC  = 2'd2,
      KIND_GSV  = 2'd3
   } kind_type;

   // sentence names, indexed [kind - 1][character]
   localparam logic [7:0] KIND_NAMES [3][3] = '{
      '{8'h47, 8'h47, 8'h41},
      '{8'h52, 8'h4D, 8'h43},
      '{8'h47, 8'h53, 8'h56}
   };

   // field numbers
   localparam logic [3:0] GGA_LAT  = 4'd2;
   localparam logic [3:0] GGA_NS   = 4'd3;
   localparam logic [3:0] GGA_LON  = 4'd4;
   localparam logic [3:0] GGA_EW   = 4'd5;
   localparam logic [3:0] GGA_FIX  = 4'd6;
   localparam logic [3:0] GGA_HDOP = 4'd8;
   localparam logic [3:0] RMC_TIME = 4'd1;
   localparam logic [3:0] RMC_LAT  = 4'd3;
   localparam logic [3:0] RMC_NS   = 4'd4;
   localparam logic [3:0] RMC_LON  = 4'd5;
   localparam logic [3:0] RMC_EW   = 4'd6;
   localparam logic [3:0] RMC_DATE = 4'd9;
   localparam logic [3:0] FIELD_COUNT = 4'd10;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic [1:0]        sentence_kind;
      logic              accepted;
      logic              checksum_ok;
      logic              position_valid;
      logic signed [31:0] latitude;
      logic signed [31:0] longitude;
      logic [HDOP_W-1:0] hdop;
      logic              time_valid;
      logic [INT_W-1:0]  time_of_day;
      logic [INT_W-1:0]  date_value;
   } rsp_type;

   // ten to the n
   function automatic logic [31:0] pow10(input logic [2:0] n);
      logic [31:0] r;
      r = 32'd1;
      for (int i = 0; i < 7; i++) begin
         if (3'(i) < n) begin
            r = r * 32'd10;
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/core/nsp_coord.sv
module nsp_coord #(
   parameter int FRACTION_DIGITS = nsp_pkg::DEF_FRACTION_DIGITS
) (
   input  logic                               clock,
   input  logic                               advance,
   input  logic                               neg,
   input  logic [nsp_pkg::DEG_W-1:0]          deg,
   input  logic [nsp_pkg::MIN_W-1:0]          mins,
   input  logic [$clog2(10**FRACTION_DIGITS)-1:0] frac,
   output logic signed [31:0]                 mag
);

   localparam int SCALE   = 10**FRACTION_DIGITS;
   localparam int KMUL    = 10**(7 - FRACTION_DIGITS);
   // ceil(2^32 / 15), exact for quotients of values below 2^28
   localparam logic [56:0] RECIP15 = 57'd286331154;

   logic [29:0] m_ff;
   logic [36:0] dege_ff, dege2_ff, dege3_ff;
   logic [27:0] y_ff;
   logic [24:0] q_ff;
   logic        neg_ff, neg2_ff, neg3_ff;
   logic [29:0] x;
   logic [56:0] p;
   logic [36:0] sum;
   logic [31:0] magc;

   // minutes scaled, degrees scaled
   // then minutes times 1e7/scale, divided by 60 as (x/4)/15
   assign x    = m_ff * 30'(KMUL);
   assign p    = 57'(y_ff) * RECIP15;
   assign sum  = dege3_ff + 37'(q_ff);
   assign magc = (sum > 37'(nsp_pkg::DEG_CAP)) ? nsp_pkg::DEG_CAP : sum[31:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         m_ff     <= 30'(mins) * 30'(SCALE) + 30'(frac);
         dege_ff  <= 37'(deg) * 37'(nsp_pkg::E7);
         neg_ff   <= neg;
         y_ff     <= x[29:2];
         dege2_ff <= dege_ff;
         neg2_ff  <= neg_ff;
         q_ff     <= p[56:32];
         dege3_ff <= dege2_ff;
         neg3_ff  <= neg2_ff;
         mag      <= neg3_ff ? -$signed(magc) : $signed(magc);
      end
   end

endmodule

>>> rtl/core/nmea_sentence_parser.sv
// NMEA line parser: one character item accepted per cycle, no gaps needed.
// A line's result passes through the input register, the parse stage and
// four coordinate conversion stages after its end-of-line item is accepted.
// Throughput: 1 item per cycle; only a held result with rsp_ready low stalls.
// Reset (synchronous, active high) clears the pipeline and line state.
module nmea_sentence_parser #(
   parameter int MAX_LINE_CHARS  = nsp_pkg::DEF_MAX_LINE_CHARS,
   parameter int FRACTION_DIGITS = nsp_pkg::DEF_FRACTION_DIGITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nsp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nsp_pkg::rsp_type rsp_data
);

   localparam int POS_W  = $clog2(MAX_LINE_CHARS + 1);
   localparam int FRAC_W = $clog2(10**FRACTION_DIGITS);
   localparam int INT_W  = nsp_pkg::INT_W;
   localparam int DEG_W  = nsp_pkg::DEG_W;
   localparam int MIN_W  = nsp_pkg::MIN_W;
   localparam int HDOP_W = nsp_pkg::HDOP_W;

   typedef enum logic [1:0] {FS_INT, FS_FRAC, FS_END} fstage_type;

   logic advance;

   // input register
   logic             in_v_ff;
   nsp_pkg::req_type in_d_ff;

   // line state
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              cut_ff, cut_in;
   logic [7:0]        xor_ff, xor_in;
   logic              star_ff, star_in;
   logic [7:0]        rsum_ff, rsum_in;
   logic [1:0]        scnt_ff, scnt_in;
   logic              sbad_ff, sbad_in;
   logic              prefix_ff, prefix_in;
   logic [2:0]        kmatch_ff, kmatch_in;
   nsp_pkg::kind_type kind_ff, kind_in;
   logic [3:0]        comma_ff, comma_in;
   logic [9:0]        flags_ff, flags_in;
   logic [1:0]        hemi_ff, hemi_in;
   logic [DEG_W-1:0]  lat_deg_ff, lat_deg_in, lon_deg_ff, lon_deg_in;
   logic [MIN_W-1:0]  lat_min_ff, lat_min_in, lon_min_ff, lon_min_in;
   logic [FRAC_W-1:0] lat_frac_ff, lat_frac_in, lon_frac_ff, lon_frac_in;
   logic [HDOP_W-1:0] hdop_ff, hdop_in;
   logic [INT_W-1:0]  time_ff, time_in, date_ff, date_in;

   // field being received
   logic              fnon_ff, fnon_in;
   logic [7:0]        ffirst_ff, ffirst_in;
   fstage_type        fstage_ff, fstage_in;
   logic [INT_W-1:0]  fint_ff, fint_in;
   logic [DEG_W-1:0]  fdeg_ff, fdeg_in;
   logic [3:0]        fmt_ff, fmt_in, fmo_ff, fmo_in;
   logic [FRAC_W-1:0] ffrac_ff, ffrac_in;
   logic [2:0]        fcnt_ff, fcnt_in;
   logic [6:0]        fhund_ff, fhund_in;
   logic [1:0]        fhn_ff, fhn_in;

   // snapshot taken at end of line
   logic              snap_v;
   nsp_pkg::rsp_type  snap;
   logic              snap_lat_neg, snap_lon_neg;
   logic [DEG_W-1:0]  snap_lat_deg, snap_lon_deg;
   logic [MIN_W-1:0]  snap_lat_min, snap_lon_min;
   logic [FRAC_W-1:0] snap_lat_frac, snap_lon_frac;

   logic              c_lat_neg_ff, c_lon_neg_ff;
   logic [DEG_W-1:0]  c_lat_deg_ff, c_lon_deg_ff;
   logic [MIN_W-1:0]  c_lat_min_ff, c_lon_min_ff;
   logic [FRAC_W-1:0] c_lat_frac_ff, c_lon_frac_ff;

   logic [4:0]       vld_ff;
   nsp_pkg::rsp_type side_ff [5];
   logic signed [31:0] lat_mag, lon_mag;

   assign advance   = !vld_ff[4] || rsp_ready;
   assign req_ready = advance;

   // parse one character
   always_comb begin
      logic [7:0]  c;
      logic        dgt;
      logic [3:0]  dv;
      logic        hex_ok;
      logic [3:0]  hexv;
      logic [2:0]  km;
      logic [1:0]  idx;
      logic        negc;
      logic [23:0] t;
      logic [26:0] h;
      logic        ck;
      logic        pv;
      logic        tv;
      nsp_pkg::kind_type kd;

      c      = in_d_ff.char_byte;
      dgt    = (c >= 8'h30) && (c <= 8'h39);
      dv     = c[3:0];
      hex_ok = 1'b0;
      hexv   = 4'd0;
      km     = 3'd0;
      idx    = 2'd0;
      negc   = (ffirst_ff == nsp_pkg::CH_S) || (ffirst_ff == nsp_pkg::CH_LS) ||
               (ffirst_ff == nsp_pkg::CH_W) || (ffirst_ff == nsp_pkg::CH_LW);
      t      = 24'd0;
      h      = 27'd0;
      ck     = 1'b0;
      pv     = 1'b0;
      tv     = 1'b0;
      kd     = nsp_pkg::KIND_NONE;

      pos_in = pos_ff;       cut_in = cut_ff;       xor_in = xor_ff;
      star_in = star_ff;     rsum_in = rsum_ff;     scnt_in = scnt_ff;
      sbad_in = sbad_ff;     prefix_in = prefix_ff; kmatch_in = kmatch_ff;
      kind_in = kind_ff;     comma_in = comma_ff;   flags_in = flags_ff;
      hemi_in = hemi_ff;
      lat_deg_in = lat_deg_ff; lat_min_in = lat_min_ff; lat_frac_in = lat_frac_ff;
      lon_deg_in = lon_deg_ff; lon_min_in = lon_min_ff; lon_frac_in = lon_frac_ff;
      hdop_in = hdop_ff;     time_in = time_ff;     date_in = date_ff;
      fnon_in = fnon_ff;     ffirst_in = ffirst_ff; fstage_in = fstage_ff;
      fint_in = fint_ff;     fdeg_in = fdeg_ff;     fmt_in = fmt_ff;
      fmo_in = fmo_ff;       ffrac_in = ffrac_ff;   fcnt_in = fcnt_ff;
      fhund_in = fhund_ff;   fhn_in = fhn_ff;

      snap_v        = 1'b0;
      snap          = '0;
      snap_lat_neg  = 1'b0; snap_lon_neg  = 1'b0;
      snap_lat_deg  = '0;   snap_lon_deg  = '0;
      snap_lat_min  = '0;   snap_lon_min  = '0;
      snap_lat_frac = '0;   snap_lon_frac = '0;

      // checksum digit decode
      if (dgt) begin
         hex_ok = 1'b1;
         hexv   = dv;
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         hex_ok = 1'b1;
         hexv   = c[3:0] + 4'd9;
      end

      if (in_v_ff) begin
         if (!cut_ff && (pos_ff < POS_W'(MAX_LINE_CHARS))) begin
            if (c == 8'h00) begin
               cut_in = 1'b1;
            end else begin
               pos_in = pos_ff + POS_W'(1);

               // prefix check
               if (pos_ff == POS_W'(0)) begin
                  prefix_in = (c == nsp_pkg::CH_DOLLAR);
               end
               if (pos_ff == POS_W'(1)) begin
                  prefix_in = prefix_ff && (c == nsp_pkg::CH_G);
               end

               // running checksum and received digits
               if (pos_ff != POS_W'(0)) begin
                  if (!star_ff) begin
                     if (c == nsp_pkg::CH_STAR) begin
                        star_in = 1'b1;
                     end else begin
                        xor_in = xor_ff ^ c;
                     end
                  end else if (scnt_ff < 2'd2) begin
                     if (!hex_ok) begin
                        sbad_in = 1'b1;
                     end else begin
                        rsum_in = {rsum_ff[3:0], hexv};
                     end
                     scnt_in = scnt_ff + 2'd1;
                  end
               end

               // sentence name match
               if ((pos_ff >= POS_W'(3)) && (pos_ff <= POS_W'(5))) begin
                  km  = (pos_ff == POS_W'(3)) ? 3'b111 : kmatch_ff;
                  idx = 2'(pos_ff - POS_W'(3));
                  for (int i = 0; i < 3; i++) begin
                     if (nsp_pkg::KIND_NAMES[i][idx] != c) begin
                        km[i] = 1'b0;
                     end
                  end
                  kmatch_in = km;
                  if (pos_ff == POS_W'(5)) begin
                     kind_in = nsp_pkg::KIND_NONE;
                     if (km[0]) kind_in = nsp_pkg::KIND_GGA;
                     if (km[1]) kind_in = nsp_pkg::KIND_RMC;
                     if (km[2]) kind_in = nsp_pkg::KIND_GSV;
                  end
               end

               if (c == nsp_pkg::CH_COMMA) begin
                  // field commit
                  if (comma_ff < nsp_pkg::FIELD_COUNT) begin
                     if (fnon_ff) flags_in[comma_ff] = 1'b1;
                     h = 27'(fhn_ff == 2'd1 ? 7'(fhund_ff * 7'd10) : fhund_ff) +
                         27'(fint_ff) * 27'd100;
                     if (kind_ff == nsp_pkg::KIND_GGA) begin
                        if (comma_ff == nsp_pkg::GGA_LAT) begin
                           lat_deg_in  = fdeg_ff;
                           lat_min_in  = 7'(fmt_ff * 7'd10) + 7'(fmo_ff);
                           lat_frac_in = ffrac_ff;
                        end
                        if (comma_ff == nsp_pkg::GGA_NS && negc) hemi_in[0] = 1'b1;
                        if (comma_ff == nsp_pkg::GGA_LON) begin
                           lon_deg_in  = fdeg_ff;
                           lon_min_in  = 7'(fmt_ff * 7'd10) + 7'(fmo_ff);
                           lon_frac_in = ffrac_ff;
                        end
                        if (comma_ff == nsp_pkg::GGA_EW && negc) hemi_in[1] = 1'b1;
                        if (comma_ff == nsp_pkg::GGA_FIX) begin
                           flags_in[6] = fnon_ff && (ffirst_ff >= 8'h31) &&
                                         (ffirst_ff <= 8'h33);
                        end
                        if (comma_ff == nsp_pkg::GGA_HDOP) begin
                           hdop_in = (h > 27'(nsp_pkg::HDOP_CAP)) ? nsp_pkg::HDOP_CAP
                                                                  : h[HDOP_W-1:0];
                        end
                     end else if (kind_ff == nsp_pkg::KIND_RMC) begin
                        if (comma_ff == nsp_pkg::RMC_TIME) time_in = fint_ff;
                        if (comma_ff == nsp_pkg::RMC_LAT) begin
                           lat_deg_in  = fdeg_ff;
                           lat_min_in  = 7'(fmt_ff * 7'd10) + 7'(fmo_ff);
                           lat_frac_in = ffrac_ff;
                        end
                        if (comma_ff == nsp_pkg::RMC_NS && negc) hemi_in[0] = 1'b1;
                        if (comma_ff == nsp_pkg::RMC_LON) begin
                           lon_deg_in  = fdeg_ff;
                           lon_min_in  = 7'(fmt_ff * 7'd10) + 7'(fmo_ff);
                           lon_frac_in = ffrac_ff;
                        end
                        if (comma_ff == nsp_pkg::RMC_EW && negc) hemi_in[1] = 1'b1;
                        if (comma_ff == nsp_pkg::RMC_DATE) date_in = fint_ff;
                     end
                  end
                  if (comma_ff != 4'd15) comma_in = comma_ff + 4'd1;
                  // field clear
                  fnon_in = 1'b0;  ffirst_in = 8'd0; fstage_in = FS_INT;
                  fint_in = '0;    fdeg_in = '0;     fmt_in = 4'd0;
                  fmo_in = 4'd0;   ffrac_in = '0;    fcnt_in = 3'd0;
                  fhund_in = 7'd0; fhn_in = 2'd0;
               end else begin
                  // field character
                  if (!fnon_ff) ffirst_in = c;
                  fnon_in = 1'b1;
                  case (fstage_ff)
                     FS_INT: begin
                        if (dgt) begin
                           t = 24'(fint_ff) * 24'd10 + 24'(dv);
                           if (t > 24'(nsp_pkg::INT_CAP)) begin
                              fint_in = nsp_pkg::INT_CAP;
                              fdeg_in = nsp_pkg::DEG_MAX;
                              fmt_in  = 4'd9;
                              fmo_in  = 4'd9;
                           end else begin
                              fint_in = t[INT_W-1:0];
                              fdeg_in = DEG_W'(fdeg_ff * 14'd10) + DEG_W'(fmt_ff);
                              fmt_in  = fmo_ff;
                              fmo_in  = dv;
                           end
                        end else begin
                           fstage_in = (c == nsp_pkg::CH_DOT) ? FS_FRAC : FS_END;
                        end
                     end
                     FS_FRAC: begin
                        if (dgt) begin
                           if (fcnt_ff < 3'(FRACTION_DIGITS)) begin
                              ffrac_in = ffrac_ff + FRAC_W'(32'(dv) *
                                 nsp_pkg::pow10(3'(FRACTION_DIGITS - 1) - fcnt_ff));
                              fcnt_in  = fcnt_ff + 3'd1;
                           end
                           if (fhn_ff < 2'd2) begin
                              fhund_in = 7'(fhund_ff * 7'd10) + 7'(dv);
                              fhn_in   = fhn_ff + 2'd1;
                           end
                        end else begin
                           fstage_in = FS_END;
                        end
                     end
                     default: begin
                        fstage_in = FS_END;
                     end
                  endcase
               end
            end
         end

         // end of line: form the result and restart
         if (in_d_ff.end_of_line) begin
            ck = prefix_in && star_in && (scnt_in == 2'd2) && !sbad_in &&
                 (rsum_in == xor_in);
            kd = ck ? kind_in : nsp_pkg::KIND_NONE;
            if (kd == nsp_pkg::KIND_GGA) begin
               pv = flags_in[2] && flags_in[3] && flags_in[4] && flags_in[5] &&
                    flags_in[6] && flags_in[8];
            end
            if (kd == nsp_pkg::KIND_RMC) begin
               pv = flags_in[3] && flags_in[4] && flags_in[5] && flags_in[6];
               tv = flags_in[1] && flags_in[9];
            end
            snap_v              = 1'b1;
            snap.sentence_kind  = kd;
            snap.accepted       = (kd != nsp_pkg::KIND_NONE);
            snap.checksum_ok    = ck;
            snap.position_valid = pv;
            if (pv && kd == nsp_pkg::KIND_GGA) begin
               snap.hdop = (hdop_in == '0) ? nsp_pkg::HDOP_ZERO : hdop_in;
            end
            snap.time_valid = tv;
            if (tv) begin
               snap.time_of_day = time_in;
               snap.date_value  = date_in;
            end
            if (pv) begin
               snap_lat_neg  = hemi_in[0];  snap_lon_neg  = hemi_in[1];
               snap_lat_deg  = lat_deg_in;  snap_lon_deg  = lon_deg_in;
               snap_lat_min  = lat_min_in;  snap_lon_min  = lon_min_in;
               snap_lat_frac = lat_frac_in; snap_lon_frac = lon_frac_in;
            end

            pos_in = '0;     cut_in = 1'b0;   xor_in = 8'd0;   star_in = 1'b0;
            rsum_in = 8'd0;  scnt_in = 2'd0;  sbad_in = 1'b0;  prefix_in = 1'b0;
            kmatch_in = 3'd0; kind_in = nsp_pkg::KIND_NONE;
            comma_in = 4'd0; flags_in = 10'd0; hemi_in = 2'd0;
            lat_deg_in = '0; lat_min_in = '0; lat_frac_in = '0;
            lon_deg_in = '0; lon_min_in = '0; lon_frac_in = '0;
            hdop_in = '0;    time_in = '0;    date_in = '0;
            fnon_in = 1'b0;  ffirst_in = 8'd0; fstage_in = FS_INT;
            fint_in = '0;    fdeg_in = '0;    fmt_in = 4'd0;   fmo_in = 4'd0;
            ffrac_in = '0;   fcnt_in = 3'd0;  fhund_in = 7'd0; fhn_in = 2'd0;
         end
      end
   end

   // control and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
         vld_ff  <= 5'd0;
         pos_ff <= '0;     cut_ff <= 1'b0;   xor_ff <= 8'd0;   star_ff <= 1'b0;
         rsum_ff <= 8'd0;  scnt_ff <= 2'd0;  sbad_ff <= 1'b0;  prefix_ff <= 1'b0;
         kmatch_ff <= 3'd0; kind_ff <= nsp_pkg::KIND_NONE;
         comma_ff <= 4'd0; flags_ff <= 10'd0; hemi_ff <= 2'd0;
         lat_deg_ff <= '0; lat_min_ff <= '0; lat_frac_ff <= '0;
         lon_deg_ff <= '0; lon_min_ff <= '0; lon_frac_ff <= '0;
         hdop_ff <= '0;    time_ff <= '0;    date_ff <= '0;
         fnon_ff <= 1'b0;  ffirst_ff <= 8'd0; fstage_ff <= FS_INT;
         fint_ff <= '0;    fdeg_ff <= '0;    fmt_ff <= 4'd0;   fmo_ff <= 4'd0;
         ffrac_ff <= '0;   fcnt_ff <= 3'd0;  fhund_ff <= 7'd0; fhn_ff <= 2'd0;
      end else if (advance) begin
         in_v_ff <= req_valid;
         vld_ff  <= {vld_ff[3:0], snap_v};
         pos_ff <= pos_in;     cut_ff <= cut_in;     xor_ff <= xor_in;
         star_ff <= star_in;   rsum_ff <= rsum_in;   scnt_ff <= scnt_in;
         sbad_ff <= sbad_in;   prefix_ff <= prefix_in; kmatch_ff <= kmatch_in;
         kind_ff <= kind_in;   comma_ff <= comma_in; flags_ff <= flags_in;
         hemi_ff <= hemi_in;
         lat_deg_ff <= lat_deg_in; lat_min_ff <= lat_min_in; lat_frac_ff <= lat_frac_in;
         lon_deg_ff <= lon_deg_in; lon_min_ff <= lon_min_in; lon_frac_ff <= lon_frac_in;
         hdop_ff <= hdop_in;   time_ff <= time_in;   date_ff <= date_in;
         fnon_ff <= fnon_in;   ffirst_ff <= ffirst_in; fstage_ff <= fstage_in;
         fint_ff <= fint_in;   fdeg_ff <= fdeg_in;   fmt_ff <= fmt_in;
         fmo_ff <= fmo_in;     ffrac_ff <= ffrac_in; fcnt_ff <= fcnt_in;
         fhund_ff <= fhund_in; fhn_ff <= fhn_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         in_d_ff       <= req_data;
         side_ff[0]    <= snap;
         for (int i = 1; i < 5; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         c_lat_neg_ff  <= snap_lat_neg;  c_lon_neg_ff  <= snap_lon_neg;
         c_lat_deg_ff  <= snap_lat_deg;  c_lon_deg_ff  <= snap_lon_deg;
         c_lat_min_ff  <= snap_lat_min;  c_lon_min_ff  <= snap_lon_min;
         c_lat_frac_ff <= snap_lat_frac; c_lon_frac_ff <= snap_lon_frac;
      end
   end

   // coordinate conversion
   nsp_coord #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_lat (
      .clock   (clock),
      .advance (advance),
      .neg     (c_lat_neg_ff),
      .deg     (c_lat_deg_ff),
      .mins    (c_lat_min_ff),
      .frac    (c_lat_frac_ff),
      .mag     (lat_mag)
   );

   nsp_coord #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_lon (
      .clock   (clock),
      .advance (advance),
      .neg     (c_lon_neg_ff),
      .deg     (c_lon_deg_ff),
      .mins    (c_lon_min_ff),
      .frac    (c_lon_frac_ff),
      .mag     (lon_mag)
   );

   // result
   assign rsp_valid = vld_ff[4];
   always_comb begin
      rsp_data           = side_ff[4];
      rsp_data.latitude  = lat_mag;
      rsp_data.longitude = lon_mag;
   end

endmodule
